>>> hw/rtl/sparse_column_cdf_sampler_unit_macros.svh
// Assertion helpers for the sparse column sampler.
// Each macro expects clk and arst_n in scope.
`ifndef SPARSE_COLUMN_CDF_SAMPLER_UNIT_MACROS_SVH
`define SPARSE_COLUMN_CDF_SAMPLER_UNIT_MACROS_SVH

// Check a consequence in the same cycle as its antecedent.
`define SCS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define SCS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/scs_pkg.sv
package scs_pkg;

	// field widths
	localparam int REQ_W  = 2;
	localparam int IDX_W  = 14;
	localparam int CS_W   = 15;
	localparam int PROB_W = 17;
	localparam int ROW_W  = 11;
	localparam int LEN_W  = 12;
	localparam int RND_W  = 17;
	localparam int STAT_W = 2;

	// running sum stays at most random + one probability
	localparam int CDF_W  = 18;

	// entry word: probability over row
	localparam int ENT_W  = PROB_W + ROW_W;

	// request codes
	localparam logic [REQ_W-1:0] REQ_COL = 2'd0;
	localparam logic [REQ_W-1:0] REQ_ENT = 2'd1;
	localparam logic [REQ_W-1:0] REQ_QRY = 2'd2;

	// status codes
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_RND   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_LEN   = 2'd2;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd3;

	// configuration reset value
	localparam logic [LEN_W-1:0] LENGTHS_RST = 12'd2048;

endpackage

>>> hw/rtl/scs_ram.sv
module scs_ram #(
	parameter int DEPTH = 2,
	parameter int WIDTH = 1,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> hw/rtl/sparse_column_cdf_sampler_unit.sv
// Channel  Handshake            Payload
// in       in_valid/in_ready    req_type, table_index, column_start, probability,
//                               target_row, source_length, random_fraction
// out      out_valid/out_ready  status, target_length
// cfg      cfg_we               cfg_wdata (lengths_in_use)
//
// Loads and rejected queries go from idle straight to the done state; an empty
// column passes through the start and end states first. A walked query visits
// one entry per cycle through the shared accumulate/compare unit fed by the entry RAM.
// in_ready is high only while the sequencer is idle.
// A finished result waits in the result registers; a held output stalls the
// sequencer in its done state. arst_n clears control state; the RAMs are not cleared.
`include "sparse_column_cdf_sampler_unit_macros.svh"

module sparse_column_cdf_sampler_unit #(
	parameter int MAX_LENGTHS    = 2048,
	parameter int MAX_ENTRIES    = 16384,
	parameter int PROB_FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [scs_pkg::REQ_W-1:0]   req_type,
	input  logic [scs_pkg::IDX_W-1:0]   table_index,
	input  logic [scs_pkg::CS_W-1:0]    column_start,
	input  logic [scs_pkg::PROB_W-1:0]  probability,
	input  logic [scs_pkg::ROW_W-1:0]   target_row,
	input  logic [scs_pkg::LEN_W-1:0]   source_length,
	input  logic [scs_pkg::RND_W-1:0]   random_fraction,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [scs_pkg::STAT_W-1:0]  status,
	output logic [scs_pkg::LEN_W-1:0]   target_length,
	input  logic                        cfg_we,
	input  logic [scs_pkg::LEN_W-1:0]   cfg_wdata
);

	localparam int CA_W  = $clog2(MAX_LENGTHS + 1);
	localparam int EA_W  = $clog2(MAX_ENTRIES);
	localparam int IX_W  = $clog2(MAX_ENTRIES + 1);
	localparam int PTR_W = (IX_W > scs_pkg::CS_W) ? IX_W : scs_pkg::CS_W;

	localparam logic [31:0]      ONE_FIX = 32'd1 << PROB_FRAC_BITS;
	localparam logic [31:0]      LEN_LIM = 32'(MAX_LENGTHS);
	localparam logic [31:0]      ENT_CAP = 32'(MAX_ENTRIES);
	localparam logic [PTR_W-1:0] ENT_LIM = PTR_W'(MAX_ENTRIES);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_START = 3'd1;
	localparam logic [2:0] ST_END   = 3'd2;
	localparam logic [2:0] ST_WALK  = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]                     state_q, state_d;
	logic [scs_pkg::LEN_W-1:0]      lengths_q;
	logic                           out_valid_q;
	logic [scs_pkg::STAT_W-1:0]     status_q;
	logic [scs_pkg::LEN_W-1:0]      target_length_q;
	logic [scs_pkg::STAT_W-1:0]     res_status_q, res_status_d;
	logic [scs_pkg::LEN_W-1:0]      res_len_q, res_len_d;
	logic [CA_W-1:0]                col_q;
	logic [scs_pkg::RND_W-1:0]      rnd_q;
	logic [PTR_W-1:0]               start_q, end_q, idx_q;
	logic [scs_pkg::CDF_W-1:0]      cdf_q;

	logic                           accept;
	logic                           res_ld, qry_ld, start_ld, walk_init, walk_adv, out_ld;
	logic [31:0]                    slot32, cols32, slen32, col32;
	logic                           rnd_bad, len_bad;
	logic                           cs_we, ent_we;
	logic [CA_W-1:0]                cs_raddr;
	logic [scs_pkg::CS_W-1:0]       cs_rd;
	logic [EA_W-1:0]                ent_raddr;
	logic [scs_pkg::ENT_W-1:0]      ent_rd;
	logic [scs_pkg::PROB_W-1:0]     ent_prob;
	logic [scs_pkg::ROW_W-1:0]      ent_row;
	logic [PTR_W-1:0]               end_raw, end_sat, idx_nx;
	logic [scs_pkg::CDF_W-1:0]      cdf_nx;
	logic                           walk_more;

	assign accept        = in_valid && in_ready;
	assign in_ready      = (state_q == ST_IDLE);
	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign target_length = target_length_q;

	// decode request checks
	assign slot32  = 32'(table_index);
	assign slen32  = 32'(source_length);
	assign cols32  = (32'(lengths_q) > LEN_LIM) ? LEN_LIM : 32'(lengths_q);
	assign col32   = slen32 - 32'd1;
	assign rnd_bad = 32'(random_fraction) > ONE_FIX;
	assign len_bad = (source_length == '0) || (slen32 > cols32);

	// column pointer store
	assign cs_we    = accept && (req_type == scs_pkg::REQ_COL) && (slot32 <= LEN_LIM);
	assign cs_raddr = (state_q == ST_IDLE) ? col32[CA_W-1:0] : col_q + CA_W'(1);

	scs_ram #(
		.DEPTH (MAX_LENGTHS + 1),
		.WIDTH (scs_pkg::CS_W)
	) u_col_ram (
		.clk   (clk),
		.we    (cs_we),
		.waddr (slot32[CA_W-1:0]),
		.wdata (column_start),
		.raddr (cs_raddr),
		.rdata (cs_rd)
	);

	// entry store, probability over row
	assign ent_we    = accept && (req_type == scs_pkg::REQ_ENT) && (slot32 < ENT_CAP);
	assign ent_raddr = (state_q == ST_WALK) ? idx_nx[EA_W-1:0] : start_q[EA_W-1:0];

	scs_ram #(
		.DEPTH (MAX_ENTRIES),
		.WIDTH (scs_pkg::ENT_W)
	) u_ent_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (slot32[EA_W-1:0]),
		.wdata ({probability, target_row}),
		.raddr (ent_raddr),
		.rdata (ent_rd)
	);

	// saturate column end and step the shared accumulate/compare unit
	assign end_raw   = PTR_W'(cs_rd);
	assign end_sat   = (end_raw > ENT_LIM) ? ENT_LIM : end_raw;
	assign ent_prob  = ent_rd[scs_pkg::ENT_W-1:scs_pkg::ROW_W];
	assign ent_row   = ent_rd[scs_pkg::ROW_W-1:0];
	assign idx_nx    = idx_q + PTR_W'(1);
	assign cdf_nx    = cdf_q + scs_pkg::CDF_W'(ent_prob);
	assign walk_more = (idx_nx < end_q) && (scs_pkg::CDF_W'(rnd_q) >= cdf_nx);

	// sequencer
	always_comb begin
		state_d      = state_q;
		res_ld       = 1'b0;
		res_status_d = scs_pkg::STAT_OK;
		res_len_d    = '0;
		qry_ld       = 1'b0;
		start_ld     = 1'b0;
		walk_init    = 1'b0;
		walk_adv     = 1'b0;
		out_ld       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req_type == scs_pkg::REQ_QRY) begin
						if (rnd_bad) begin
							res_ld       = 1'b1;
							res_status_d = scs_pkg::STAT_RND;
							state_d      = ST_DONE;
						end else if (len_bad) begin
							res_ld       = 1'b1;
							res_status_d = scs_pkg::STAT_LEN;
							state_d      = ST_DONE;
						end else begin
							qry_ld  = 1'b1;
							state_d = ST_START;
						end
					end else begin
						res_ld  = 1'b1;
						state_d = ST_DONE;
					end
				end
			end
			ST_START: begin
				start_ld = 1'b1;
				state_d  = ST_END;
			end
			ST_END: begin
				if (end_sat <= start_q) begin
					res_ld       = 1'b1;
					res_status_d = scs_pkg::STAT_EMPTY;
					state_d      = ST_DONE;
				end else begin
					walk_init = 1'b1;
					state_d   = ST_WALK;
				end
			end
			ST_WALK: begin
				if (walk_more) begin
					walk_adv = 1'b1;
				end else begin
					res_ld    = 1'b1;
					res_len_d = scs_pkg::LEN_W'(ent_row) + scs_pkg::LEN_W'(1);
					state_d   = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_ld  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			lengths_q   <= scs_pkg::LENGTHS_RST;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				lengths_q <= cfg_wdata;
			end
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (res_ld) begin
			res_status_q <= res_status_d;
			res_len_q    <= res_len_d;
		end
		if (qry_ld) begin
			col_q <= col32[CA_W-1:0];
			rnd_q <= random_fraction;
		end
		if (start_ld) begin
			start_q <= PTR_W'(cs_rd);
		end
		if (walk_init) begin
			end_q <= end_sat;
			idx_q <= start_q;
			cdf_q <= '0;
		end else if (walk_adv) begin
			idx_q <= idx_nx;
			cdf_q <= cdf_nx;
		end
		if (out_ld) begin
			status_q        <= res_status_q;
			target_length_q <= res_len_q;
		end
	end

	// checks
	`SCS_ASSERT_NOW(a_walk_in_col, state_q == ST_WALK, idx_q < end_q, "walk index past column end")
	`SCS_ASSERT_NOW(a_walk_cdf, state_q == ST_WALK, cdf_q <= scs_pkg::CDF_W'(rnd_q), "walk sum above random value")
	`SCS_ASSERT_NEXT(a_accept_busy, accept, state_q != ST_IDLE, "accepted transaction left no work")
	`SCS_ASSERT_NEXT(a_done_push, (state_q == ST_DONE) && (!out_valid_q || out_ready), out_valid_q && (state_q == ST_IDLE), "finished result not pushed")

endmodule
